// ----- rtl/core/qau_pkg.sv -----
// Shared types and operation codes for the quaternion arithmetic unit.
package qau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [2:0] FUNC_PRODUCT   = 3'd0;
    localparam logic [2:0] FUNC_ROTATE    = 3'd1;
    localparam logic [2:0] FUNC_INVERSE   = 3'd2;
    localparam logic [2:0] FUNC_NORMALIZE = 3'd3;
    localparam logic [2:0] FUNC_MATRIX    = 3'd4;
    localparam logic [2:0] FUNC_DOT       = 3'd5;
    localparam logic [2:0] FUNC_MAGNITUDE = 3'd6;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
    } qau_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_w;
        logic signed [31:0] scalar;
        logic               degenerate;
        logic               last;
    } qau_out_t;

endpackage

// ----- rtl/core/quaternion_arith_unit_core.sv -----
// Quaternion arithmetic unit: fully pipelined product, rotate, inverse, normalize, matrix, dot, magnitude.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+--------------------------------------
//  command  | start, busy, cmd            | beat taken at edge with start && !busy
//  result   | valid, result               | one-cycle strobe, always taken
//
//  One command enters per cycle while busy is low; a matrix command enters as three row
//  beats, so busy stays high until its last row beat has been issued.
//  Each beat strobes valid once at the end of the pipeline; the depth is set
//  by the square-root pipeline (33 stages) and the divider lanes (33 stages), one bit each.
//  Reset clears the valid bits and the replay counter; payload registers are not reset.
//  Results are never held back, so the pipeline never stalls.
module quaternion_arith_unit_core #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qau_pkg::qau_in_t  cmd,
    output logic              valid,
    output qau_pkg::qau_out_t result
);
    import qau_pkg::*;

    localparam int SW    = 68;
    localparam int DW    = 32 + 2 * FRAC_BITS;
    localparam int CW    = 65 + 33;
    localparam int T_LEN = 34;
    localparam int T_DIV = 35;
    localparam int T_DRN = 69;
    localparam int T_MUL = 70;
    localparam int T_SUM = 71;
    localparam int T_OUT = 72;

    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] ONE  = SW'(1) << (2 * FRAC_BITS);
    localparam logic signed [SW-1:0] SMAX = SW'(32'h7FFF_FFFF);
    localparam logic signed [SW-1:0] SMIN = ~SMAX;
    localparam logic [64:0] LIM = 65'(((64'(1) << (2 * FRAC_BITS)) - 64'(1)) / 64'(10000));

    typedef struct packed {
        logic [2:0]       func;
        qau_out_t         res;
        logic [3:0][31:0] a;
        logic [64:0]      n;
    } pl_t;

    function automatic logic signed [SW-1:0] sx(input logic signed [63:0] x);
        return SW'(x);
    endfunction

    function automatic logic signed [31:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] v;
        v = (s + HALF) >>> FRAC_BITS;
        if (v > SMAX)
            return 32'h7FFF_FFFF;
        if (v < SMIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Hamilton product component k from the 4x4 cross products p[i][j] = q_i * r_j
    function automatic logic signed [SW-1:0] hsum(input logic signed [63:0] p [4][4],
                                                   input logic [1:0] k);
        logic signed [SW-1:0] s;
        case (k)
            2'd0:    s = sx(p[3][0]) + sx(p[0][3]) + sx(p[1][2]) - sx(p[2][1]);
            2'd1:    s = sx(p[3][1]) - sx(p[0][2]) + sx(p[1][3]) + sx(p[2][0]);
            2'd2:    s = sx(p[3][2]) + sx(p[0][1]) - sx(p[1][0]) + sx(p[2][3]);
            default: s = sx(p[3][3]) - sx(p[0][0]) - sx(p[1][1]) - sx(p[2][2]);
        endcase
        return s;
    endfunction

    function automatic logic signed [SW-1:0] mt_diag(input logic signed [63:0] p,
                                                      input logic signed [63:0] q);
        return ONE - ((sx(p) + sx(q)) <<< 1);
    endfunction

    function automatic logic signed [SW-1:0] mt_off(input logic signed [63:0] p,
                                                     input logic signed [63:0] q,
                                                     input logic sub);
        return sub ? ((sx(p) - sx(q)) <<< 1) : ((sx(p) + sx(q)) <<< 1);
    endfunction

    function automatic logic [31:0] sat_q(input logic [33:0] q, input logic ovf,
                                          input logic neg);
        logic [33:0] nq;
        nq = ~q + 34'd1;
        if (neg)
            return (!ovf && q <= 34'h0_8000_0000) ? nq[31:0] : 32'h8000_0000;
        return (!ovf && q <= 34'h0_7FFF_FFFF) ? q[31:0] : 32'h7FFF_FFFF;
    endfunction

    // ---------------- issue: matrix commands replay as three row beats
    logic [1:0]         rep_reg;
    qau_in_t            hold_reg;
    qau_in_t            src;
    logic               accept;

    logic               s0_v_reg;
    logic [2:0]         s0_func_reg;
    logic [1:0]         s0_row_reg;
    logic               s0_last_reg;
    logic signed [31:0] s0_a_reg [4];
    logic signed [31:0] s0_b_reg [4];

    assign busy   = (rep_reg != 2'd0);
    assign accept = start && !busy;
    assign src    = accept ? cmd : hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_reg  <= 2'd0;
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= accept || busy;
            if (accept)
                rep_reg <= (cmd.func == FUNC_MATRIX) ? 2'd2 : 2'd0;
            else if (busy)
                rep_reg <= rep_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= cmd;
        s0_func_reg <= src.func;
        s0_a_reg[0] <= src.a_x;
        s0_a_reg[1] <= src.a_y;
        s0_a_reg[2] <= src.a_z;
        s0_a_reg[3] <= src.a_w;
        s0_b_reg[0] <= src.b_x;
        s0_b_reg[1] <= src.b_y;
        s0_b_reg[2] <= src.b_z;
        s0_b_reg[3] <= src.b_w;
        if (accept)
        begin
            s0_row_reg  <= 2'd0;
            s0_last_reg <= (cmd.func != FUNC_MATRIX);
        end
        else
        begin
            s0_row_reg  <= (rep_reg == 2'd2) ? 2'd1 : 2'd2;
            s0_last_reg <= (rep_reg == 2'd1);
        end
    end

    // ---------------- stage 1: cross products and squares of a
    logic signed [31:0] mop [4];
    logic               p1_v_reg;
    logic [2:0]         p1_func_reg;
    logic [1:0]         p1_row_reg;
    logic               p1_last_reg;
    logic signed [31:0] p1_a_reg [4];
    logic signed [63:0] p1_pr_reg [4][4];
    logic signed [63:0] p1_sq_reg [4];

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            mop[j] = (s0_func_reg == FUNC_MATRIX) ? s0_a_reg[j] : s0_b_reg[j];
            if (s0_func_reg == FUNC_ROTATE && j == 3)
                mop[j] = 32'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_func_reg <= s0_func_reg;
        p1_row_reg  <= s0_row_reg;
        p1_last_reg <= s0_last_reg;
        for (int i = 0; i < 4; i++)
        begin
            p1_a_reg[i]  <= s0_a_reg[i];
            p1_sq_reg[i] <= s0_a_reg[i] * s0_a_reg[i];
            for (int j = 0; j < 4; j++)
                p1_pr_reg[i][j] <= s0_a_reg[i] * mop[j];
        end
    end

    // ---------------- stage 2: exact sums
    logic               p2_v_reg;
    logic [2:0]         p2_func_reg;
    logic               p2_last_reg;
    logic signed [31:0] p2_a_reg [4];
    logic signed [SW-1:0] p2_qs_reg [4];
    logic signed [SW-1:0] p2_ds_reg;
    logic signed [SW-1:0] p2_ms_reg [3];
    logic [64:0]        p2_n_reg;

    always_ff @(posedge clk)
    begin
        p2_func_reg <= p1_func_reg;
        p2_last_reg <= p1_last_reg;
        for (int i = 0; i < 4; i++)
        begin
            p2_a_reg[i]  <= p1_a_reg[i];
            p2_qs_reg[i] <= hsum(p1_pr_reg, 2'(i));
        end
        p2_ds_reg <= sx(p1_pr_reg[0][0]) + sx(p1_pr_reg[1][1])
                   + sx(p1_pr_reg[2][2]) + sx(p1_pr_reg[3][3]);
        p2_n_reg  <= 65'($unsigned(p1_sq_reg[0])) + 65'($unsigned(p1_sq_reg[1]))
                   + 65'($unsigned(p1_sq_reg[2])) + 65'($unsigned(p1_sq_reg[3]));
        case (p1_row_reg)
            2'd0:
            begin
                p2_ms_reg[0] <= mt_diag(p1_pr_reg[1][1], p1_pr_reg[2][2]);
                p2_ms_reg[1] <= mt_off(p1_pr_reg[0][1], p1_pr_reg[2][3], 1'b1);
                p2_ms_reg[2] <= mt_off(p1_pr_reg[0][2], p1_pr_reg[1][3], 1'b0);
            end
            2'd1:
            begin
                p2_ms_reg[0] <= mt_off(p1_pr_reg[0][1], p1_pr_reg[2][3], 1'b0);
                p2_ms_reg[1] <= mt_diag(p1_pr_reg[0][0], p1_pr_reg[2][2]);
                p2_ms_reg[2] <= mt_off(p1_pr_reg[1][2], p1_pr_reg[0][3], 1'b1);
            end
            2'd2:
            begin
                p2_ms_reg[0] <= mt_off(p1_pr_reg[0][2], p1_pr_reg[1][3], 1'b1);
                p2_ms_reg[1] <= mt_off(p1_pr_reg[1][2], p1_pr_reg[0][3], 1'b0);
                p2_ms_reg[2] <= mt_diag(p1_pr_reg[0][0], p1_pr_reg[1][1]);
            end
            default:
            begin
                p2_ms_reg[0] <= '0;
                p2_ms_reg[1] <= '0;
                p2_ms_reg[2] <= '0;
            end
        endcase
    end

    // ---------------- tail pipeline
    logic        tv_reg [0:T_OUT];
    pl_t         tp_reg [0:T_OUT];
    logic [32:0] sqm_reg [0:33];
    logic [65:0] sqr_reg [0:33];
    logic [32:0] sql_reg;

    logic [64:0] dd_reg  [T_DIV:T_DRN-1];
    logic [65:0] dr_reg  [T_DIV:T_DRN-1][4];
    logic [32:0] dq_reg  [T_DIV:T_DRN-1][4];
    logic [32:0] dlo_reg [T_DIV:T_DRN-1][4];
    logic [3:0]  dov_reg [T_DIV:T_DRN-1];
    logic [3:0]  dng_reg [T_DIV:T_DRN-1];

    logic signed [31:0] inv_reg [4];
    logic signed [63:0] mp_reg [4][4];
    logic signed [SW-1:0] ms2_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            for (int k = 0; k <= T_OUT; k++)
                tv_reg[k] <= 1'b0;
        end
        else
        begin
            p1_v_reg  <= s0_v_reg;
            p2_v_reg  <= p1_v_reg;
            tv_reg[0] <= p2_v_reg;
            for (int k = 0; k < T_OUT; k++)
                tv_reg[k+1] <= tv_reg[k];
        end
    end

    // stage 3: round early results, degenerate tests
    qau_out_t early;
    logic     deg;

    always_comb
    begin
        early      = '0;
        early.last = p2_last_reg;
        unique case (p2_func_reg)
            FUNC_PRODUCT, FUNC_ROTATE:
            begin
                early.r_x = round_sat(p2_qs_reg[0]);
                early.r_y = round_sat(p2_qs_reg[1]);
                early.r_z = round_sat(p2_qs_reg[2]);
                early.r_w = round_sat(p2_qs_reg[3]);
            end
            FUNC_MATRIX:
            begin
                early.r_x = round_sat(p2_ms_reg[0]);
                early.r_y = round_sat(p2_ms_reg[1]);
                early.r_z = round_sat(p2_ms_reg[2]);
            end
            FUNC_DOT:
                early.scalar = round_sat(p2_ds_reg);
            default:
                early.scalar = 32'sd0;
        endcase
        unique case (p2_func_reg)
            FUNC_ROTATE, FUNC_INVERSE: deg = (p2_n_reg <= LIM);
            FUNC_NORMALIZE:            deg = (p2_n_reg == 65'd0);
            default:                   deg = 1'b0;
        endcase
        early.degenerate = deg;
    end

    always_ff @(posedge clk)
    begin
        tp_reg[0].func <= p2_func_reg;
        tp_reg[0].res  <= early;
        tp_reg[0].n    <= p2_n_reg;
        for (int i = 0; i < 4; i++)
            tp_reg[0].a[i] <= p2_a_reg[i];
        sqm_reg[0] <= 33'd0;
        sqr_reg[0] <= 66'(p2_n_reg);
    end

    // square root of the squared norm, one result bit per stage
    for (genvar k = 0; k < 33; k++)
    begin : g_sqrt
        localparam int B = 32 - k;
        logic [65:0] term;
        logic        ge;
        assign term = (66'(sqm_reg[k]) << (B + 1)) + (66'(1) << (2 * B));
        assign ge   = (sqr_reg[k] >= term);
        always_ff @(posedge clk)
        begin
            tp_reg[k+1]  <= tp_reg[k];
            sqr_reg[k+1] <= ge ? (sqr_reg[k] - term) : sqr_reg[k];
            sqm_reg[k+1] <= ge ? (sqm_reg[k] | (33'(1) << B)) : sqm_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg[T_LEN] <= tp_reg[T_LEN-1];
        sql_reg <= sqm_reg[33] + 33'((sqr_reg[33] > 66'(sqm_reg[33])) ? 1 : 0);
    end

    // divider setup: dividend per lane, shared divisor, overflow check
    logic          nrm;
    logic [64:0]   dsel;
    logic [31:0]   mag  [4];
    logic          negv [4];
    logic [DW-1:0] dvd  [4];
    pl_t           pl_len;

    always_comb
    begin
        nrm  = (tp_reg[T_LEN].func == FUNC_NORMALIZE);
        dsel = nrm ? 65'(sql_reg) : tp_reg[T_LEN].n;
        pl_len = tp_reg[T_LEN];
        if (tp_reg[T_LEN].func == FUNC_MAGNITUDE)
            pl_len.res.scalar = (sql_reg > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : sql_reg[31:0];
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = tp_reg[T_LEN].a[i][31] ? (~tp_reg[T_LEN].a[i] + 32'd1)
                                             : tp_reg[T_LEN].a[i];
            if (nrm || i == 3)
                negv[i] = tp_reg[T_LEN].a[i][31];
            else
                negv[i] = !tp_reg[T_LEN].a[i][31] && (tp_reg[T_LEN].a[i] != 32'd0);
            dvd[i] = DW'(mag[i]) << (nrm ? FRAC_BITS : 2 * FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg[T_DIV] <= pl_len;
        dd_reg[T_DIV] <= dsel;
        for (int i = 0; i < 4; i++)
        begin
            dr_reg[T_DIV][i]  <= 66'(dvd[i] >> 33);
            dq_reg[T_DIV][i]  <= 33'd0;
            dlo_reg[T_DIV][i] <= dvd[i][32:0];
            dov_reg[T_DIV][i] <= (CW'(dvd[i]) >= (CW'(dsel) << 33));
            dng_reg[T_DIV][i] <= negv[i];
        end
    end

    // restoring division, four lanes, one quotient bit per stage
    for (genvar j = 0; j < 33; j++)
    begin : g_div
        localparam int K = 32 - j;
        localparam int I = T_DIV + j;
        logic [65:0] rs [4];
        logic        ge [4];
        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                rs[i] = {dr_reg[I][i][64:0], dlo_reg[I][i][K]};
                ge[i] = (rs[i] >= {1'b0, dd_reg[I]});
            end
        end
        always_ff @(posedge clk)
        begin
            tp_reg[I+1]  <= tp_reg[I];
            dd_reg[I+1]  <= dd_reg[I];
            dov_reg[I+1] <= dov_reg[I];
            dng_reg[I+1] <= dng_reg[I];
            for (int i = 0; i < 4; i++)
            begin
                dr_reg[I+1][i]  <= ge[i] ? (rs[i] - {1'b0, dd_reg[I]}) : rs[i];
                dq_reg[I+1][i]  <= dq_reg[I][i] | (33'(ge[i]) << K);
                dlo_reg[I+1][i] <= dlo_reg[I][i];
            end
        end
    end

    // round quotients half up, saturate with sign
    logic [31:0] quo [4];
    pl_t         pl_drn;

    always_comb
    begin
        pl_drn = tp_reg[T_DRN-1];
        for (int i = 0; i < 4; i++)
            quo[i] = sat_q(34'(dq_reg[T_DRN-1][i])
                           + 34'(({dr_reg[T_DRN-1][i], 1'b0} >= {2'b0, dd_reg[T_DRN-1]})
                                 ? 1 : 0),
                           dov_reg[T_DRN-1][i], dng_reg[T_DRN-1][i]);
        if (pl_drn.func == FUNC_INVERSE || pl_drn.func == FUNC_NORMALIZE)
        begin
            pl_drn.res.r_x = quo[0];
            pl_drn.res.r_y = quo[1];
            pl_drn.res.r_z = quo[2];
            pl_drn.res.r_w = quo[3];
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg[T_DRN] <= pl_drn;
        for (int i = 0; i < 4; i++)
            inv_reg[i] <= quo[i];
    end

    // rotation: t * inv(a)
    logic signed [31:0] tq [4];
    assign tq[0] = tp_reg[T_DRN].res.r_x;
    assign tq[1] = tp_reg[T_DRN].res.r_y;
    assign tq[2] = tp_reg[T_DRN].res.r_z;
    assign tq[3] = tp_reg[T_DRN].res.r_w;

    always_ff @(posedge clk)
    begin
        tp_reg[T_MUL] <= tp_reg[T_DRN];
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                mp_reg[i][j] <= tq[i] * inv_reg[j];
    end

    always_ff @(posedge clk)
    begin
        tp_reg[T_SUM] <= tp_reg[T_MUL];
        for (int i = 0; i < 4; i++)
            ms2_reg[i] <= hsum(mp_reg, 2'(i));
    end

    pl_t pl_out;

    always_comb
    begin
        pl_out = tp_reg[T_SUM];
        if (pl_out.func == FUNC_ROTATE)
        begin
            pl_out.res.r_x = round_sat(ms2_reg[0]);
            pl_out.res.r_y = round_sat(ms2_reg[1]);
            pl_out.res.r_z = round_sat(ms2_reg[2]);
            pl_out.res.r_w = 32'sd0;
        end
        // drop the quaternion on a degenerate norm
        if (pl_out.res.degenerate)
        begin
            pl_out.res.r_x = 32'sd0;
            pl_out.res.r_y = 32'sd0;
            pl_out.res.r_z = 32'sd0;
            pl_out.res.r_w = 32'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        tp_reg[T_OUT] <= pl_out;
    end

    assign valid  = tv_reg[T_OUT];
    assign result = tp_reg[T_OUT].res;

endmodule

// ----- rtl/core/qau_checker.sv -----
// Port-level assertions for the quaternion arithmetic unit, bound to the top level.
module qau_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input qau_pkg::qau_in_t  cmd,
    input logic              valid,
    input qau_pkg::qau_out_t result
);
    import qau_pkg::*;

    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !valid && !busy)
        else $error("strobe or busy during reset");

    a_matrix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func == FUNC_MATRIX) |=> busy ##1 busy)
        else $error("matrix beat not held for its rows");

    a_single_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.func != FUNC_MATRIX) |=> !busy)
        else $error("busy after a single-result command");

    a_rows_back: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !result.last) |=> valid)
        else $error("matrix rows not back to back");

    a_row_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !result.last) |-> (result.r_w == 0 && result.scalar == 0
                                     && !result.degenerate))
        else $error("matrix row carries quaternion fields");

endmodule

bind quaternion_arith_unit_core qau_checker u_qau_checker (.*);
